// ===== hdl/teq_pkg.sv =====
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types and constants of the timed event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int unsigned EventCount = 16;
  localparam int unsigned TimeBits   = 32;
  localparam int unsigned IdBits     = 4;

  typedef enum logic [2:0] {
    CMD_POST   = 3'd0,
    CMD_CANCEL = 3'd1,
    CMD_TIMED  = 3'd2,
    CMD_TAKE   = 3'd3,
    CMD_DUE    = 3'd4,
    CMD_PEEK   = 3'd5
  } command_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_QUEUED  = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NOT_DUE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PL_NONE  = 2'd0,
    PL_IMM   = 2'd1,
    PL_TIMED = 2'd2
  } place_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_REMOVE,
    S_SEARCH,
    S_INSERT,
    S_HEAD,
    S_DONE
  } state_t;

endpackage

// ===== hdl/teq_cmp.sv =====
// ----------------------------------------------------------------------------
// teq_cmp
// Shared modular time compare: le is high when a <= b in wraparound order.
// ----------------------------------------------------------------------------
module teq_cmp #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic [TIME_BITS-1:0] a,
  input  logic [TIME_BITS-1:0] b,
  output logic                 le
);

  logic [TIME_BITS-1:0] diff;

  // Top bit of the wrapped difference clear means a is not later than b
  assign diff = b - a;
  assign le   = ~diff[TIME_BITS-1];

endmodule

// ===== hdl/timed_event_queue.sv =====
// ----------------------------------------------------------------------------
// timed_event_queue
// Scheduler for a fixed set of events held in an immediate FIFO and a list
// sorted by expiry time.
// ----------------------------------------------------------------------------
// One command is in flight at a time; in_ready is low from the input transfer
// until the result transfer. Post, peek, a due take whose head is not yet due
// and a cancel of an unqueued event go from the head state straight to the
// done state. A take or a due take closes the gap at the list head one entry
// per cycle. A cancel of a queued event walks its list one entry per cycle to
// find it, then closes the gap. A timed post then searches the sorted list
// through one shared time comparator, one entry per cycle, and shifts the
// tail up one entry per cycle to open the slot. The longest case is
// re-posting an event already on a full timed list; a stalled out_ready adds
// its wait on top. Lists hold entries in order registers.
module timed_event_queue
  import teq_pkg::*;
#(
  parameter int unsigned EVENT_COUNT = EventCount,
  parameter int unsigned TIME_BITS   = TimeBits
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           command,
  input  logic [IdBits-1:0]    event_id,
  input  logic [TIME_BITS-1:0] expire_time,
  input  logic [TIME_BITS-1:0] current_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic [IdBits-1:0]    taken_id,
  output logic [TIME_BITS-1:0] next_time
);

  localparam int unsigned EB = (EVENT_COUNT > 1) ? $clog2(EVENT_COUNT) : 1;
  localparam int unsigned CB = $clog2(EVENT_COUNT + 1);

  state_t state, state_next;

  place_t              place  [EVENT_COUNT];
  logic [TIME_BITS-1:0] expiry [EVENT_COUNT];
  logic [EB-1:0]       imm_ord [EVENT_COUNT];
  logic [EB-1:0]       tim_ord [EVENT_COUNT];
  logic [CB-1:0]       imm_cnt, tim_cnt;

  logic [2:0]           cmd;
  logic [IdBits-1:0]    id_r;
  logic [TIME_BITS-1:0] exp_r, now_r;
  logic                 use_tim;   // list being walked is the timed one
  logic [CB-1:0]        idx;

  logic [EB-1:0]        id_e;
  logic                 id_ok;
  logic [CB-1:0]        cnt_sel;
  logic [EB-1:0]        ent_sel, ent_nxt;
  logic [EB-1:0]        idx_e;
  logic [TIME_BITS-1:0] cmp_a, cmp_b;
  logic                 le;

  assign id_e  = EB'(id_r);
  assign id_ok = {28'd0, id_r} < 32'(EVENT_COUNT);
  assign idx_e = idx[EB-1:0];
  assign cnt_sel = use_tim ? tim_cnt : imm_cnt;
  assign ent_sel = use_tim ? tim_ord[idx_e] : imm_ord[idx_e];
  assign ent_nxt = use_tim ? tim_ord[EB'(idx + 1'b1)] : imm_ord[EB'(idx + 1'b1)];

  // Shared comparator: search compares new expiry to an entry, due check
  // compares head expiry to present time
  always_comb begin
    if (state == S_SEARCH) begin
      cmp_a = exp_r;
      cmp_b = expiry[tim_ord[idx_e]];
    end else begin
      cmp_a = expiry[tim_ord[0]];
      cmp_b = now_r;
    end
  end

  teq_cmp #(.TIME_BITS(TIME_BITS)) u_cmp (.a(cmp_a), .b(cmp_b), .le(le));

  assign in_ready = (state == S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_HEAD;
      S_HEAD: begin
        priority if ((cmd == CMD_CANCEL || cmd == CMD_TIMED) && id_ok
                     && place[id_e] != PL_NONE)
          state_next = S_FIND;
        else if (cmd == CMD_TIMED && id_ok)
          state_next = S_SEARCH;
        else if (cmd == CMD_TAKE && imm_cnt != '0)
          state_next = S_REMOVE;
        else if (cmd == CMD_DUE && tim_cnt != '0 && le)
          state_next = S_REMOVE;
        else
          state_next = S_DONE;
      end
      S_FIND: if (ent_sel == id_e || idx + 1'b1 >= cnt_sel) state_next = S_REMOVE;
      S_REMOVE:
        if (idx + 1'b1 >= cnt_sel)
          state_next = (cmd == CMD_TIMED) ? S_SEARCH : S_DONE;
      S_SEARCH:
        if (idx >= tim_cnt || le) state_next = S_INSERT;
      S_INSERT: if (idx == CB'(now_r)) state_next = S_DONE;
      S_DONE:   if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  assign out_valid = (state == S_DONE);

  // Datapath and list updates
  always_ff @(posedge clk) begin
    if (rst) begin
      imm_cnt <= '0;
      tim_cnt <= '0;
      for (int i = 0; i < EVENT_COUNT; i++) place[i] <= PL_NONE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          cmd     <= command;
          id_r    <= event_id;
          exp_r   <= expire_time;
          now_r   <= current_time;
          status  <= ST_OK;
          taken_id <= '0;
          next_time <= '0;
          idx     <= '0;
        end
        S_HEAD: begin
          // Pick the list to walk: timed for a due take or a timed entry
          use_tim <= (cmd == CMD_DUE) ||
                     ((cmd == CMD_CANCEL || cmd == CMD_TIMED) && place[id_e] == PL_TIMED);
          idx     <= '0;
          unique case (cmd)
            CMD_POST: if (id_ok) begin
              if (place[id_e] != PL_NONE) status <= ST_QUEUED;
              else begin
                imm_ord[imm_cnt[EB-1:0]] <= id_e;
                imm_cnt <= imm_cnt + 1'b1;
                place[id_e] <= PL_IMM;
              end
            end
            CMD_TAKE: begin
              if (imm_cnt == '0) status <= ST_EMPTY;
              else begin
                taken_id <= IdBits'(imm_ord[0]);
                place[imm_ord[0]] <= PL_NONE;
              end
            end
            CMD_DUE: begin
              if (tim_cnt == '0) status <= ST_EMPTY;
              else if (!le) status <= ST_NOT_DUE;
              else begin
                taken_id <= IdBits'(tim_ord[0]);
                place[tim_ord[0]] <= PL_NONE;
              end
            end
            CMD_PEEK: begin
              if (tim_cnt == '0) status <= ST_EMPTY;
              else next_time <= expiry[tim_ord[0]];
            end
            CMD_CANCEL, CMD_TIMED: if (id_ok) place[id_e] <= PL_NONE;
            default: ;
          endcase
        end
        S_FIND: if (ent_sel != id_e) idx <= idx + 1'b1;
        S_REMOVE: begin
          // Close the gap one entry per cycle
          if (idx + 1'b1 < cnt_sel) begin
            if (use_tim) tim_ord[idx_e] <= ent_nxt;
            else         imm_ord[idx_e] <= ent_nxt;
            idx <= idx + 1'b1;
          end else begin
            if (use_tim) tim_cnt <= tim_cnt - 1'b1;
            else         imm_cnt <= imm_cnt - 1'b1;
            idx <= '0;
          end
        end
        S_SEARCH: begin
          if (idx < tim_cnt && !le) idx <= idx + 1'b1;
          else begin
            expiry[id_e] <= exp_r;
            now_r <= {{(TIME_BITS-CB){1'b0}}, idx}; // hold insert position
            idx <= tim_cnt;
          end
        end
        S_INSERT: begin
          // Shift entries up from the tail, then place the new one
          if (idx == tim_cnt[CB-1:0] && CB'(now_r) == idx) begin
            tim_ord[idx_e] <= id_e;
            tim_cnt <= tim_cnt + 1'b1;
            place[id_e] <= PL_TIMED;
          end else if (idx > CB'(now_r)) begin
            tim_ord[idx_e] <= tim_ord[EB'(idx - 1'b1)];
            idx <= idx - 1'b1;
          end else begin
            tim_ord[idx_e] <= id_e;
            tim_cnt <= tim_cnt + 1'b1;
            place[id_e] <= PL_TIMED;
            idx <= tim_cnt;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
